### rtl/tce_pkg.sv
// Shared types, codes and defaults for the tiny CPU instruction executor.
`default_nettype none
package tce_pkg;

	localparam int MEMORY_BYTES_DEF = 256;

	// action codes of an input item
	localparam logic [2:0] ACT_WR    = 3'd0;
	localparam logic [2:0] ACT_RD    = 3'd1;
	localparam logic [2:0] ACT_RREG  = 3'd2;
	localparam logic [2:0] ACT_START = 3'd3;
	localparam logic [2:0] ACT_STEP  = 3'd4;

	// fault codes
	localparam logic [2:0] F_NONE  = 3'd0;
	localparam logic [2:0] F_OVER  = 3'd1;
	localparam logic [2:0] F_UNDER = 3'd2;
	localparam logic [2:0] F_DIV   = 3'd3;
	localparam logic [2:0] F_MOD   = 3'd4;
	localparam logic [2:0] F_ADDR  = 3'd5;
	localparam logic [2:0] F_OP    = 3'd6;

	// opcodes
	localparam logic [7:0] OP_LDI  = 8'd0;
	localparam logic [7:0] OP_HLT  = 8'd1;
	localparam logic [7:0] OP_ADD  = 8'd2;
	localparam logic [7:0] OP_SUB  = 8'd3;
	localparam logic [7:0] OP_MUL  = 8'd4;
	localparam logic [7:0] OP_DIV  = 8'd5;
	localparam logic [7:0] OP_MOD  = 8'd6;
	localparam logic [7:0] OP_CMP  = 8'd7;
	localparam logic [7:0] OP_JZ   = 8'd8;
	localparam logic [7:0] OP_JNZ  = 8'd9;
	localparam logic [7:0] OP_JMP  = 8'd10;
	localparam logic [7:0] OP_PUSH = 8'd11;
	localparam logic [7:0] OP_POP  = 8'd12;
	localparam logic [7:0] OP_CALL = 8'd13;
	localparam logic [7:0] OP_RET  = 8'd14;
	localparam logic [7:0] OP_MOV  = 8'd15;
	localparam logic [7:0] OP_IRET = 8'd16;
	localparam logic [7:0] OP_NOP  = 8'd17;
	localparam logic [7:0] OP_STI  = 8'd18;
	localparam logic [7:0] OP_CLI  = 8'd19;
	localparam logic [7:0] OP_LDR  = 8'd20;
	localparam logic [7:0] OP_STR  = 8'd21;
	localparam logic [7:0] OP_LAST = OP_STR;

	// memory address select
	localparam logic [3:0] MA_IN   = 4'd0;
	localparam logic [3:0] MA_PC   = 4'd1;
	localparam logic [3:0] MA_SP   = 4'd2;
	localparam logic [3:0] MA_SPM1 = 4'd3;
	localparam logic [3:0] MA_SPM2 = 4'd4;
	localparam logic [3:0] MA_SPP1 = 4'd5;
	localparam logic [3:0] MA_A    = 4'd6;
	localparam logic [3:0] MA_B    = 4'd7;
	localparam logic [3:0] MA_CLR  = 4'd8;

	// memory write data select
	localparam logic [2:0] MW_ZERO = 3'd0;
	localparam logic [2:0] MW_DATA = 3'd1;
	localparam logic [2:0] MW_X    = 3'd2;
	localparam logic [2:0] MW_Y    = 3'd3;
	localparam logic [2:0] MW_PCLO = 3'd4;
	localparam logic [2:0] MW_PCHI = 3'd5;

	// pc load select
	localparam logic [1:0] PC_HOLD = 2'd0;
	localparam logic [1:0] PC_IN   = 2'd1;
	localparam logic [1:0] PC_A    = 2'd2;
	localparam logic [1:0] PC_POP  = 2'd3;

	// stack pointer update
	localparam logic [2:0] SP_HOLD = 3'd0;
	localparam logic [2:0] SP_DEC1 = 3'd1;
	localparam logic [2:0] SP_DEC2 = 3'd2;
	localparam logic [2:0] SP_INC1 = 3'd3;
	localparam logic [2:0] SP_INC2 = 3'd4;

	// register file read index select
	localparam logic [1:0] RR_IN = 2'd0;
	localparam logic [1:0] RR_R1 = 2'd1;
	localparam logic [1:0] RR_R2 = 2'd2;

	// register file write data select
	localparam logic [2:0] RW_B   = 3'd0;
	localparam logic [2:0] RW_ALU = 3'd1;
	localparam logic [2:0] RW_QUO = 3'd2;
	localparam logic [2:0] RW_REM = 3'd3;
	localparam logic [2:0] RW_Y   = 3'd4;
	localparam logic [2:0] RW_MEM = 3'd5;

	// alu operation
	localparam logic [1:0] ALU_ADD = 2'd0;
	localparam logic [1:0] ALU_SUB = 2'd1;
	localparam logic [1:0] ALU_MUL = 2'd2;

	// zero flag source
	localparam logic ZS_W  = 1'b0;
	localparam logic ZS_EQ = 1'b1;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] address;
		logic [7:0]  data;
	} tce_in_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [15:0] program_counter;
		logic        running;
		logic        zero_flag;
		logic        interrupt_enable;
		logic [2:0]  fault;
	} tce_out_t;

	// controller to datapath
	typedef struct packed {
		logic       take;
		logic       mem_we;
		logic       mem_re;
		logic [3:0] mem_asel;
		logic [2:0] mem_wsel;
		logic       pc_inc;
		logic [1:0] pc_sel;
		logic [2:0] sp_op;
		logic       rf_re;
		logic [1:0] rf_rsel;
		logic       rf_we;
		logic [2:0] rf_wsel;
		logic       rf_clr;
		logic [1:0] alu_op;
		logic       zf_ld;
		logic       zf_sel;
		logic       ie_set;
		logic       ie_clr;
		logic       run_set;
		logic       run_clr;
		logic       ld_op;
		logic       ld_a;
		logic       ld_b;
		logic       ld_x;
		logic       ld_y;
		logic       ld_lo;
		logic       ld_rdata;
		logic       rd_from_mem;
		logic       fault_ld;
		logic [2:0] fault_code;
		logic       div_start;
		logic       clr_inc;
	} tce_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] action;
		logic [7:0] op;
		logic       addr_ok;
		logic       pc_ok;
		logic       a_ok;
		logic       b_ok;
		logic       run;
		logic       zf;
		logic       y_zero;
		logic       sp_lt1;
		logic       sp_lt2;
		logic       sp_empty;
		logic       sp_one;
		logic       div_done;
		logic       clr_last;
	} tce_stat_t;

endpackage
`default_nettype wire

### rtl/tiny_cpu_instruction_executor.sv
// Top level of the tiny CPU instruction executor.
//
//  channel   signals               direction  handshake
//  item      start, busy, item     in         taken when start && !busy
//  result    done, result          out        valid for the single cycle done is high
//
// A memory write or start passes through dispatch to the response; memory and
// register reads add a capture state. A step fetches the opcode, decodes it,
// fetches each operand byte, reads two registers and executes; DIV/MOD also wait
// for the bit-serial divider. A step while halted goes straight to the response.
// The single memory port sets the fetch cost.
// After reset busy stays high while memory and registers are cleared. The result
// cannot be held off: done lasts one cycle.
`default_nettype none
module tiny_cpu_instruction_executor #(
	parameter int MEMORY_BYTES = tce_pkg::MEMORY_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire tce_pkg::tce_in_t item,
	output logic                  busy,
	output logic                  done,
	output tce_pkg::tce_out_t     result
);
	import tce_pkg::*;

	tce_cmd_t  cmd;
	tce_stat_t stat;

	tce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tce_dp #(
		.MEMORY_BYTES (MEMORY_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);
endmodule
`default_nettype wire

### rtl/tce_div.sv
// Restoring 8-bit divider, one quotient bit per cycle.
`default_nettype none
module tce_div (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [7:0] dividend,
	input  wire logic [7:0] divisor,
	output logic [7:0]      quotient,
	output logic [7:0]      remainder,
	output logic            done
);
	logic [7:0] rem_q;
	logic [7:0] quo_q;
	logic [7:0] dvs_q;
	logic [2:0] cnt_q;
	logic       act_q;
	logic       done_q;
	logic [8:0] trial;
	logic [8:0] diff;
	logic       fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[7]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			act_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (act_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				act_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (act_q) begin
			rem_q <= fits ? diff[7:0] : trial[7:0];
			quo_q <= {quo_q[6:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;
endmodule
`default_nettype wire

### rtl/tce_ctrl.sv
// Sequencer for actions and instruction steps of the executor.
`default_nettype none
module tce_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire tce_pkg::tce_stat_t stat,
	output tce_pkg::tce_cmd_t       cmd,
	output logic                    busy,
	output logic                    done
);
	import tce_pkg::*;

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DISP  = 5'd2;
	localparam logic [4:0] S_CAP   = 5'd3;
	localparam logic [4:0] S_FOP   = 5'd4;
	localparam logic [4:0] S_WOP   = 5'd5;
	localparam logic [4:0] S_DEC   = 5'd6;
	localparam logic [4:0] S_FA    = 5'd7;
	localparam logic [4:0] S_WA    = 5'd8;
	localparam logic [4:0] S_FB    = 5'd9;
	localparam logic [4:0] S_WB    = 5'd10;
	localparam logic [4:0] S_RX    = 5'd11;
	localparam logic [4:0] S_RY    = 5'd12;
	localparam logic [4:0] S_RW    = 5'd13;
	localparam logic [4:0] S_EXEC  = 5'd14;
	localparam logic [4:0] S_DIVW  = 5'd15;
	localparam logic [4:0] S_POPW  = 5'd16;
	localparam logic [4:0] S_CALL2 = 5'd17;
	localparam logic [4:0] S_RET1  = 5'd18;
	localparam logic [4:0] S_RET2  = 5'd19;
	localparam logic [4:0] S_LDRW  = 5'd20;
	localparam logic [4:0] S_RESP  = 5'd21;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic [1:0] nops;

	// operand byte count per opcode
	always_comb begin
		unique case (stat.op)
			OP_HLT, OP_RET, OP_IRET, OP_NOP, OP_STI, OP_CLI: nops = 2'd0;
			OP_JZ, OP_JNZ, OP_JMP, OP_PUSH, OP_POP, OP_CALL: nops = 2'd1;
			default:                                         nops = 2'd2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_RESP;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.mem_we   = 1'b1;
				cmd.mem_asel = MA_CLR;
				cmd.mem_wsel = MW_ZERO;
				cmd.rf_we    = 1'b1;
				cmd.rf_clr   = 1'b1;
				cmd.clr_inc  = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.take = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_RESP;
				unique case (stat.action)
					ACT_WR: begin
						if (stat.addr_ok) begin
							cmd.mem_we   = 1'b1;
							cmd.mem_asel = MA_IN;
							cmd.mem_wsel = MW_DATA;
						end else begin
							cmd.fault_ld   = 1'b1;
							cmd.fault_code = F_ADDR;
						end
					end
					ACT_RD: begin
						if (stat.addr_ok) begin
							cmd.mem_re   = 1'b1;
							cmd.mem_asel = MA_IN;
							state_d      = S_CAP;
						end else begin
							cmd.fault_ld   = 1'b1;
							cmd.fault_code = F_ADDR;
						end
					end
					ACT_RREG: begin
						cmd.rf_re   = 1'b1;
						cmd.rf_rsel = RR_IN;
						state_d     = S_CAP;
					end
					ACT_START: begin
						cmd.pc_sel  = PC_IN;
						cmd.run_set = 1'b1;
					end
					ACT_STEP: begin
						if (stat.run) state_d = S_FOP;
					end
					default: ;
				endcase
			end
			S_CAP: begin
				cmd.ld_rdata    = 1'b1;
				cmd.rd_from_mem = stat.action == ACT_RD;
				state_d         = S_RESP;
			end
			S_FOP, S_FA, S_FB: begin
				if (!stat.pc_ok) begin
					cmd.run_clr    = 1'b1;
					cmd.fault_ld   = 1'b1;
					cmd.fault_code = F_ADDR;
					state_d        = S_RESP;
				end else begin
					cmd.mem_re   = 1'b1;
					cmd.mem_asel = MA_PC;
					cmd.pc_inc   = 1'b1;
					state_d      = (state_q == S_FOP) ? S_WOP :
					               (state_q == S_FA) ? S_WA : S_WB;
				end
			end
			S_WOP: begin
				cmd.ld_op = 1'b1;
				state_d   = S_DEC;
			end
			S_DEC: begin
				if (stat.op > OP_LAST) begin
					cmd.run_clr    = 1'b1;
					cmd.fault_ld   = 1'b1;
					cmd.fault_code = F_OP;
					state_d        = S_RESP;
				end else if (nops != 2'd0) begin
					state_d = S_FA;
				end else begin
					state_d = S_RX;
				end
			end
			S_WA: begin
				cmd.ld_a = 1'b1;
				state_d  = (nops == 2'd2) ? S_FB : S_RX;
			end
			S_WB: begin
				cmd.ld_b = 1'b1;
				state_d  = S_RX;
			end
			S_RX: begin
				cmd.rf_re   = 1'b1;
				cmd.rf_rsel = RR_R1;
				state_d     = S_RY;
			end
			S_RY: begin
				cmd.ld_x    = 1'b1;
				cmd.rf_re   = 1'b1;
				cmd.rf_rsel = RR_R2;
				state_d     = S_RW;
			end
			S_RW: begin
				cmd.ld_y = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_RESP;
				unique case (stat.op)
					OP_LDI: begin
						cmd.rf_we   = 1'b1;
						cmd.rf_wsel = RW_B;
					end
					OP_HLT: cmd.run_clr = 1'b1;
					OP_ADD, OP_SUB, OP_MUL: begin
						cmd.rf_we   = 1'b1;
						cmd.rf_wsel = RW_ALU;
						cmd.alu_op  = (stat.op == OP_ADD) ? ALU_ADD :
						              (stat.op == OP_SUB) ? ALU_SUB : ALU_MUL;
						cmd.zf_ld   = 1'b1;
						cmd.zf_sel  = ZS_W;
					end
					OP_DIV, OP_MOD: begin
						if (stat.y_zero) begin
							cmd.run_clr    = 1'b1;
							cmd.fault_ld   = 1'b1;
							cmd.fault_code = (stat.op == OP_DIV) ? F_DIV : F_MOD;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIVW;
						end
					end
					OP_CMP: begin
						cmd.zf_ld  = 1'b1;
						cmd.zf_sel = ZS_EQ;
					end
					OP_JZ:  if (stat.zf)  cmd.pc_sel = PC_A;
					OP_JNZ: if (!stat.zf) cmd.pc_sel = PC_A;
					OP_JMP: cmd.pc_sel = PC_A;
					OP_PUSH: begin
						if (stat.sp_lt1) begin
							cmd.run_clr    = 1'b1;
							cmd.fault_ld   = 1'b1;
							cmd.fault_code = F_OVER;
						end else begin
							cmd.mem_we   = 1'b1;
							cmd.mem_asel = MA_SPM1;
							cmd.mem_wsel = MW_X;
							cmd.sp_op    = SP_DEC1;
						end
					end
					OP_POP: begin
						if (stat.sp_empty) begin
							cmd.run_clr    = 1'b1;
							cmd.fault_ld   = 1'b1;
							cmd.fault_code = F_UNDER;
						end else begin
							cmd.mem_re   = 1'b1;
							cmd.mem_asel = MA_SP;
							state_d      = S_POPW;
						end
					end
					OP_CALL: begin
						if (stat.sp_lt2) begin
							cmd.run_clr    = 1'b1;
							cmd.fault_ld   = 1'b1;
							cmd.fault_code = F_OVER;
						end else begin
							cmd.mem_we   = 1'b1;
							cmd.mem_asel = MA_SPM2;
							cmd.mem_wsel = MW_PCLO;
							state_d      = S_CALL2;
						end
					end
					OP_RET, OP_IRET: begin
						if (stat.sp_one) begin
							cmd.run_clr    = 1'b1;
							cmd.fault_ld   = 1'b1;
							cmd.fault_code = F_UNDER;
						end else begin
							cmd.mem_re   = 1'b1;
							cmd.mem_asel = MA_SP;
							state_d      = S_RET1;
						end
					end
					OP_MOV: begin
						cmd.rf_we   = 1'b1;
						cmd.rf_wsel = RW_Y;
					end
					OP_STI: cmd.ie_set = 1'b1;
					OP_CLI: cmd.ie_clr = 1'b1;
					OP_LDR: begin
						if (!stat.b_ok) begin
							cmd.run_clr    = 1'b1;
							cmd.fault_ld   = 1'b1;
							cmd.fault_code = F_ADDR;
						end else begin
							cmd.mem_re   = 1'b1;
							cmd.mem_asel = MA_B;
							state_d      = S_LDRW;
						end
					end
					OP_STR: begin
						if (!stat.a_ok) begin
							cmd.run_clr    = 1'b1;
							cmd.fault_ld   = 1'b1;
							cmd.fault_code = F_ADDR;
						end else begin
							cmd.mem_we   = 1'b1;
							cmd.mem_asel = MA_A;
							cmd.mem_wsel = MW_Y;
						end
					end
					default: ;
				endcase
			end
			S_DIVW: begin
				if (stat.div_done) begin
					cmd.rf_we   = 1'b1;
					cmd.rf_wsel = (stat.op == OP_DIV) ? RW_QUO : RW_REM;
					cmd.zf_ld   = 1'b1;
					cmd.zf_sel  = ZS_W;
					state_d     = S_RESP;
				end
			end
			S_POPW: begin
				cmd.rf_we   = 1'b1;
				cmd.rf_wsel = RW_MEM;
				cmd.sp_op   = SP_INC1;
				state_d     = S_RESP;
			end
			S_CALL2: begin
				cmd.mem_we   = 1'b1;
				cmd.mem_asel = MA_SPM1;
				cmd.mem_wsel = MW_PCHI;
				cmd.sp_op    = SP_DEC2;
				cmd.pc_sel   = PC_A;
				state_d      = S_RESP;
			end
			S_RET1: begin
				cmd.ld_lo    = 1'b1;
				cmd.mem_re   = 1'b1;
				cmd.mem_asel = MA_SPP1;
				state_d      = S_RET2;
			end
			S_RET2: begin
				cmd.pc_sel = PC_POP;
				cmd.sp_op  = SP_INC2;
				state_d    = S_RESP;
			end
			S_LDRW: begin
				cmd.rf_we   = 1'b1;
				cmd.rf_wsel = RW_MEM;
				state_d     = S_RESP;
			end
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/tce_dp.sv
// Datapath: memory, register file, machine state, alu and divider.
`default_nettype none
module tce_dp #(
	parameter int MEMORY_BYTES = tce_pkg::MEMORY_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tce_pkg::tce_in_t  item,
	input  wire tce_pkg::tce_cmd_t cmd,
	output tce_pkg::tce_stat_t     stat,
	output tce_pkg::tce_out_t      result
);
	import tce_pkg::*;

	localparam int AW  = $clog2(MEMORY_BYTES);
	localparam int SPW = $clog2(MEMORY_BYTES + 1);
	localparam logic [16:0]  MB17 = 17'(MEMORY_BYTES);
	localparam logic [SPW:0] MBSP = (SPW + 1)'(MEMORY_BYTES);

	logic [7:0]     mem [MEMORY_BYTES];
	logic [7:0]     rf [8];
	logic [7:0]     mem_q;
	logic [7:0]     rf_q;
	tce_in_t        in_q;
	logic [15:0]    pc_q;
	logic [SPW-1:0] sp_q;
	logic           zf_q;
	logic           ie_q;
	logic           run_q;
	logic [AW-1:0]  clr_q;
	logic [7:0]     op_q;
	logic [7:0]     a_q;
	logic [7:0]     b_q;
	logic [7:0]     x_q;
	logic [7:0]     y_q;
	logic [7:0]     lo_q;
	logic [7:0]     rdata_q;
	logic [2:0]     fault_q;

	logic [AW-1:0]  maddr;
	logic [7:0]     mwdat;
	logic [2:0]     ridx;
	logic [2:0]     widx;
	logic [7:0]     wval;
	logic [7:0]     alu;
	logic [15:0]    prod;
	logic [7:0]     quo;
	logic [7:0]     rem;
	logic           div_done;
	logic [SPW:0]   sp_p1;

	// divider for DIV and MOD
	tce_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (x_q),
		.divisor   (y_q),
		.quotient  (quo),
		.remainder (rem),
		.done      (div_done)
	);

	// memory address and write data
	always_comb begin
		case (cmd.mem_asel)
			MA_IN:   maddr = in_q.address[AW-1:0];
			MA_PC:   maddr = pc_q[AW-1:0];
			MA_SP:   maddr = sp_q[AW-1:0];
			MA_SPM1: maddr = AW'(sp_q - SPW'(1));
			MA_SPM2: maddr = AW'(sp_q - SPW'(2));
			MA_SPP1: maddr = AW'(sp_q + SPW'(1));
			MA_A:    maddr = AW'(a_q);
			MA_B:    maddr = AW'(b_q);
			default: maddr = clr_q;
		endcase
		case (cmd.mem_wsel)
			MW_DATA: mwdat = in_q.data;
			MW_X:    mwdat = x_q;
			MW_Y:    mwdat = y_q;
			MW_PCLO: mwdat = pc_q[7:0];
			MW_PCHI: mwdat = pc_q[15:8];
			default: mwdat = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) mem[maddr] <= mwdat;
		if (cmd.mem_re) mem_q <= mem[maddr];
	end

	// alu and register file write value
	assign prod = x_q * y_q;
	always_comb begin
		case (cmd.alu_op)
			ALU_ADD: alu = x_q + y_q;
			ALU_SUB: alu = x_q - y_q;
			default: alu = prod[7:0];
		endcase
		case (cmd.rf_wsel)
			RW_B:    wval = b_q;
			RW_ALU:  wval = alu;
			RW_QUO:  wval = quo;
			RW_REM:  wval = rem;
			RW_Y:    wval = y_q;
			RW_MEM:  wval = mem_q;
			default: wval = 8'd0;
		endcase
		case (cmd.rf_rsel)
			RR_IN:   ridx = in_q.address[2:0];
			RR_R1:   ridx = a_q[2:0];
			default: ridx = b_q[2:0];
		endcase
	end

	assign widx = cmd.rf_clr ? clr_q[2:0] : a_q[2:0];

	always_ff @(posedge clk) begin
		if (cmd.rf_we) rf[widx] <= cmd.rf_clr ? 8'd0 : wval;
		if (cmd.rf_re) rf_q <= rf[ridx];
	end

	// machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			sp_q  <= SPW'(MEMORY_BYTES);
			zf_q  <= 1'b0;
			ie_q  <= 1'b0;
			run_q <= 1'b0;
			clr_q <= '0;
		end else begin
			if (cmd.clr_inc) clr_q <= clr_q + AW'(1);
			case (cmd.pc_sel)
				PC_IN:   pc_q <= in_q.address;
				PC_A:    pc_q <= {8'd0, a_q};
				PC_POP:  pc_q <= {mem_q, lo_q};
				default: if (cmd.pc_inc) pc_q <= pc_q + 16'd1;
			endcase
			case (cmd.sp_op)
				SP_DEC1: sp_q <= sp_q - SPW'(1);
				SP_DEC2: sp_q <= sp_q - SPW'(2);
				SP_INC1: sp_q <= sp_q + SPW'(1);
				SP_INC2: sp_q <= sp_q + SPW'(2);
				default: ;
			endcase
			if (cmd.zf_ld) zf_q <= (cmd.zf_sel == ZS_EQ) ? (x_q == y_q) : (wval == 8'd0);
			if (cmd.ie_set) ie_q <= 1'b1;
			else if (cmd.ie_clr) ie_q <= 1'b0;
			if (cmd.run_set) run_q <= 1'b1;
			else if (cmd.run_clr) run_q <= 1'b0;
		end
	end

	// item, operand and result holding registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			in_q    <= item;
			rdata_q <= 8'd0;
			fault_q <= F_NONE;
			a_q     <= 8'd0;
			b_q     <= 8'd0;
		end else begin
			if (cmd.ld_rdata) rdata_q <= cmd.rd_from_mem ? mem_q : rf_q;
			if (cmd.fault_ld) fault_q <= cmd.fault_code;
			if (cmd.ld_op)    op_q <= mem_q;
			if (cmd.ld_a)     a_q <= mem_q;
			if (cmd.ld_b)     b_q <= mem_q;
		end
		if (cmd.ld_x)  x_q  <= rf_q;
		if (cmd.ld_y)  y_q  <= rf_q;
		if (cmd.ld_lo) lo_q <= mem_q;
	end

	// status toward the controller
	assign sp_p1 = {1'b0, sp_q} + (SPW + 1)'(1);
	always_comb begin
		stat.action   = in_q.action;
		stat.op       = op_q;
		stat.addr_ok  = {1'b0, in_q.address} < MB17;
		stat.pc_ok    = {1'b0, pc_q} < MB17;
		stat.a_ok     = 17'(a_q) < MB17;
		stat.b_ok     = 17'(b_q) < MB17;
		stat.run      = run_q;
		stat.zf       = zf_q;
		stat.y_zero   = y_q == 8'd0;
		stat.sp_lt1   = sp_q < SPW'(1);
		stat.sp_lt2   = sp_q < SPW'(2);
		stat.sp_empty = {1'b0, sp_q} >= MBSP;
		stat.sp_one   = sp_p1 >= MBSP;
		stat.div_done = div_done;
		stat.clr_last = clr_q == AW'(MEMORY_BYTES - 1);
	end

	assign result.read_data        = rdata_q;
	assign result.program_counter  = pc_q;
	assign result.running          = run_q;
	assign result.zero_flag        = zf_q;
	assign result.interrupt_enable = ie_q;
	assign result.fault            = fault_q;
endmodule
`default_nettype wire

### tb/sv/tiny_cpu_instruction_executor_test.sv
// Self-checking testbench of the tiny CPU instruction executor: programs, steps, memory access.
`timescale 1ns / 1ps
module tiny_cpu_instruction_executor_test;
	import tce_pkg::*;

	localparam int MEM_DEPTH = MEMORY_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1550;

	logic clk;
	logic arst_n;
	logic start;
	tce_in_t item;
	logic busy;
	logic done;
	tce_out_t result;

	tiny_cpu_instruction_executor #(.MEMORY_BYTES(MEM_DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result)
	);

	// machine state as predicted
	logic [7:0]  mem_img [MEM_DEPTH];
	logic [7:0]  reg_img [8];
	logic [15:0] pc_img;
	int unsigned sp_img;
	logic        zf_img, ie_img, run_img;

	tce_in_t  pending_items[$];
	tce_out_t expected_results[$];
	int       error_count;
	logic     stim_done;
	logic     burst_mode;

	// fetch one byte at pc; false when outside memory
	function automatic logic fetch_byte(output logic [7:0] b);
		if (pc_img >= MEM_DEPTH) begin
			b = '0;
			return 1'b0;
		end
		b = mem_img[pc_img];
		pc_img = pc_img + 16'd1;
		return 1'b1;
	endfunction

	// one instruction; returns fault code
	function automatic logic [2:0] exec_instr();
		logic [7:0] op, a, b;
		logic [2:0] r1, r2;
		int nops;
		a = '0;
		b = '0;
		if (!fetch_byte(op)) begin
			run_img = 0;
			return F_ADDR;
		end
		if (op > OP_LAST) begin
			run_img = 0;
			return F_OP;
		end
		case (op)
			OP_HLT, OP_RET, OP_IRET, OP_NOP, OP_STI, OP_CLI: nops = 0;
			OP_JZ, OP_JNZ, OP_JMP, OP_PUSH, OP_POP, OP_CALL: nops = 1;
			default: nops = 2;
		endcase
		if (nops >= 1 && !fetch_byte(a)) begin
			run_img = 0;
			return F_ADDR;
		end
		if (nops >= 2 && !fetch_byte(b)) begin
			run_img = 0;
			return F_ADDR;
		end
		r1 = a[2:0];
		r2 = b[2:0];
		case (op)
			OP_LDI: reg_img[r1] = b;
			OP_HLT: run_img = 0;
			OP_ADD: begin
				reg_img[r1] = reg_img[r1] + reg_img[r2];
				zf_img = reg_img[r1] == 0;
			end
			OP_SUB: begin
				reg_img[r1] = reg_img[r1] - reg_img[r2];
				zf_img = reg_img[r1] == 0;
			end
			OP_MUL: begin
				reg_img[r1] = reg_img[r1] * reg_img[r2];
				zf_img = reg_img[r1] == 0;
			end
			OP_DIV, OP_MOD: begin
				if (reg_img[r2] == 0) begin
					run_img = 0;
					return (op == OP_DIV) ? F_DIV : F_MOD;
				end
				reg_img[r1] = (op == OP_DIV) ? reg_img[r1] / reg_img[r2]
					: reg_img[r1] % reg_img[r2];
				zf_img = reg_img[r1] == 0;
			end
			OP_CMP: zf_img = reg_img[r1] == reg_img[r2];
			OP_JZ: if (zf_img) pc_img = {8'd0, a};
			OP_JNZ: if (!zf_img) pc_img = {8'd0, a};
			OP_JMP: pc_img = {8'd0, a};
			OP_PUSH: begin
				if (sp_img < 1) begin
					run_img = 0;
					return F_OVER;
				end
				sp_img--;
				mem_img[sp_img] = reg_img[r1];
			end
			OP_POP: begin
				if (sp_img >= MEM_DEPTH) begin
					run_img = 0;
					return F_UNDER;
				end
				reg_img[r1] = mem_img[sp_img];
				sp_img++;
			end
			OP_CALL: begin
				if (sp_img < 2) begin
					run_img = 0;
					return F_OVER;
				end
				sp_img -= 2;
				mem_img[sp_img] = pc_img[7:0];
				mem_img[sp_img + 1] = pc_img[15:8];
				pc_img = {8'd0, a};
			end
			OP_RET, OP_IRET: begin
				if (sp_img + 1 >= MEM_DEPTH) begin
					run_img = 0;
					return F_UNDER;
				end
				pc_img = {mem_img[sp_img + 1], mem_img[sp_img]};
				sp_img += 2;
			end
			OP_MOV: reg_img[r1] = reg_img[r2];
			OP_NOP: ;
			OP_STI: ie_img = 1;
			OP_CLI: ie_img = 0;
			OP_LDR: begin
				if (b >= MEM_DEPTH) begin
					run_img = 0;
					return F_ADDR;
				end
				reg_img[r1] = mem_img[b];
			end
			default: begin
				if (a >= MEM_DEPTH) begin
					run_img = 0;
					return F_ADDR;
				end
				mem_img[a] = reg_img[r2];
			end
		endcase
		return F_NONE;
	endfunction

	// expected result of one accepted item
	function automatic tce_out_t predict_result(tce_in_t it);
		tce_out_t r;
		r = '0;
		case (it.action)
			ACT_WR: if (it.address < MEM_DEPTH) mem_img[it.address] = it.data;
				else r.fault = F_ADDR;
			ACT_RD: if (it.address < MEM_DEPTH) r.read_data = mem_img[it.address];
				else r.fault = F_ADDR;
			ACT_RREG: r.read_data = reg_img[it.address[2:0]];
			ACT_START: begin
				pc_img = it.address;
				run_img = 1;
			end
			ACT_STEP: if (run_img) r.fault = exec_instr();
			default: ;
		endcase
		r.program_counter = pc_img;
		r.running = run_img;
		r.zero_flag = zf_img;
		r.interrupt_enable = ie_img;
		return r;
	endfunction

	function automatic tce_in_t mk(logic [2:0] act, logic [15:0] adr, logic [7:0] dat);
		tce_in_t t;
		t.action = act;
		t.address = adr;
		t.data = dat;
		return t;
	endfunction

	// random instruction byte: mostly valid opcodes
	function automatic logic [7:0] rand_op();
		if ($urandom_range(0, 19) == 0) return 8'($urandom_range(22, 255));
		return 8'($urandom_range(0, 21));
	endfunction

	// load a random program, init some registers, then run a burst of steps
	task automatic queue_program();
		int base, len, nsteps;
		base = $urandom_range(0, 3) == 0 ? $urandom_range(200, 255) : $urandom_range(0, 60);
		len = $urandom_range(4, 24);
		for (int i = 0; i < len && base + i < 256; i++) begin
			logic [7:0] v;
			int k;
			k = $urandom_range(0, 2);
			v = (k == 0) ? rand_op() : (k == 1) ? 8'($urandom_range(0, 7))
				: 8'($urandom);
			pending_items.push_back(mk(ACT_WR, 16'(base + i), v));
		end
		for (int i = 0; i < $urandom_range(0, 3); i++) begin
			pending_items.push_back(mk(ACT_WR, 16'(base), OP_LDI));
			pending_items.push_back(mk(ACT_WR, 16'(base + 1), 8'($urandom_range(0, 7))));
			pending_items.push_back(mk(ACT_WR, 16'(base + 2), 8'($urandom)));
			pending_items.push_back(mk(ACT_START, 16'(base), 8'($urandom)));
			pending_items.push_back(mk(ACT_STEP, 16'($urandom), 8'($urandom)));
		end
		pending_items.push_back(mk(ACT_START,
			$urandom_range(0, 15) == 0 ? 16'($urandom) : 16'(base), 8'($urandom)));
		nsteps = $urandom_range(3, 20);
		for (int i = 0; i < nsteps; i++)
			pending_items.push_back(mk(ACT_STEP, 16'($urandom), 8'($urandom)));
		for (int i = 0; i < 2; i++)
			pending_items.push_back(mk(ACT_RREG, 16'($urandom), 8'($urandom)));
	endtask

	// noise: any action, any address
	task automatic queue_noise();
		logic [15:0] adr;
		adr = $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : 16'($urandom);
		pending_items.push_back(mk(3'($urandom_range(0, 7)), adr, 8'($urandom)));
	endtask

	task automatic queue_stack_program();
		// push loop until overflow, then pops until underflow
		pending_items.push_back(mk(ACT_WR, 16'd0, OP_PUSH));
		pending_items.push_back(mk(ACT_WR, 16'd1, 8'd3));
		pending_items.push_back(mk(ACT_WR, 16'd2, OP_JMP));
		pending_items.push_back(mk(ACT_WR, 16'd3, 8'd0));
		pending_items.push_back(mk(ACT_START, 16'd0, 8'd0));
		for (int i = 0; i < 2 * 256 + 4; i++)
			pending_items.push_back(mk(ACT_STEP, 16'd0, 8'd0));
		pending_items.push_back(mk(ACT_WR, 16'd0, OP_POP));
		pending_items.push_back(mk(ACT_START, 16'd0, 8'd0));
		for (int i = 0; i < 2 * 256 + 4; i++)
			pending_items.push_back(mk(ACT_STEP, 16'd0, 8'd0));
	endtask

	function automatic logic predict_and_pop();
		tce_in_t it;
		it = pending_items.pop_front();
		expected_results.push_back(predict_result(it));
		return 1'b1;
	endfunction

	// clock and reset
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	// directed items, then random ones
	initial begin
		logic [7:0] prog [];
		foreach (mem_img[i]) mem_img[i] = '0;
		foreach (reg_img[i]) reg_img[i] = '0;
		pc_img = '0;
		sp_img = MEM_DEPTH;
		zf_img = 0;
		ie_img = 0;
		run_img = 0;
		error_count = 0;
		stim_done = 0;
		// step while halted, bad addresses, unused action, extremes
		pending_items.push_back(mk(ACT_STEP, 16'd0, 8'd0));
		pending_items.push_back(mk(ACT_WR, 16'hFFFF, 8'hFF));
		pending_items.push_back(mk(ACT_RD, 16'd256, 8'h00));
		pending_items.push_back(mk(3'd7, 16'hFFFF, 8'hFF));
		pending_items.push_back(mk(ACT_WR, 16'd255, 8'hFF));
		pending_items.push_back(mk(ACT_RD, 16'd255, 8'h00));
		// LDI,MUL,DIV,MOD,ADD,SUB,CMP,STI,CLI,CALL,IRET,MOV,LDR,STR,NOP,JZ,JNZ,HLT
		prog = '{OP_LDI, 1, 8'hFF, OP_LDI, 2, 3, OP_MUL, 1, 2, OP_DIV, 1, 2,
			OP_MOD, 1, 2, OP_ADD, 1, 2, OP_SUB, 1, 1, OP_CMP, 1, 1, OP_STI, OP_CLI,
			OP_CALL, 40, OP_MOV, 3, 1, OP_LDR, 4, 255, OP_STR, 200, 4, OP_JZ, 43,
			OP_HLT};
		foreach (prog[i]) pending_items.push_back(mk(ACT_WR, 16'(i), prog[i]));
		pending_items.push_back(mk(ACT_WR, 16'd40, OP_NOP));
		pending_items.push_back(mk(ACT_WR, 16'd41, OP_IRET));
		pending_items.push_back(mk(ACT_WR, 16'd43, OP_JNZ));
		pending_items.push_back(mk(ACT_WR, 16'd44, OP_DIV));
		pending_items.push_back(mk(ACT_WR, 16'd45, 8'd5));
		pending_items.push_back(mk(ACT_WR, 16'd46, 8'd6));
		pending_items.push_back(mk(ACT_START, 16'd0, 8'd0));
		for (int i = 0; i < 22; i++) pending_items.push_back(mk(ACT_STEP, 16'd0, 8'd0));
		// modulo by zero, RET underflow, bad opcode, fetch past end
		pending_items.push_back(mk(ACT_WR, 16'd44, OP_MOD));
		pending_items.push_back(mk(ACT_START, 16'd44, 8'd0));
		pending_items.push_back(mk(ACT_STEP, 16'd0, 8'd0));
		pending_items.push_back(mk(ACT_WR, 16'd50, OP_RET));
		pending_items.push_back(mk(ACT_WR, 16'd51, 8'hFF));
		pending_items.push_back(mk(ACT_START, 16'd50, 8'd0));
		pending_items.push_back(mk(ACT_STEP, 16'd0, 8'd0));
		pending_items.push_back(mk(ACT_START, 16'd51, 8'd0));
		pending_items.push_back(mk(ACT_STEP, 16'd0, 8'd0));
		pending_items.push_back(mk(ACT_START, 16'hFFFF, 8'd0));
		pending_items.push_back(mk(ACT_STEP, 16'd0, 8'd0));
		pending_items.push_back(mk(ACT_START, 16'd255, 8'd0));
		pending_items.push_back(mk(ACT_STEP, 16'd0, 8'd0));
		for (int i = 0; i < 8; i++) pending_items.push_back(mk(ACT_RREG, 16'(i), 8'd0));
		queue_stack_program();
		// random items fill up to the total item count
		for (int n = pending_items.size(); n < RANDOM_ITEMS;) begin
			int before_cnt;
			before_cnt = pending_items.size();
			if ($urandom_range(0, 9) < 8) queue_program();
			else queue_noise();
			n += pending_items.size() - before_cnt;
		end
		stim_done = 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			item <= '0;
			burst_mode <= 0;
		end else begin
			logic accepted;
			logic want;
			accepted = start && !busy;
			if (accepted) void'(predict_and_pop());
			if ($urandom_range(0, 299) == 0) burst_mode <= !burst_mode;
			want = pending_items.size() > 0 && (burst_mode || $urandom_range(0, 99) >= 26);
			if (accepted || !start) begin
				if (want) begin
					start <= 1;
					item <= pending_items[0];
				end else begin
					start <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no item outstanding");
				error_count++;
			end else begin
				tce_out_t e;
				e = expected_results.pop_front();
				if (result.read_data !== e.read_data) begin
					$error("read_data exp %0h got %0h", e.read_data, result.read_data);
					error_count++;
				end
				if (result.program_counter !== e.program_counter) begin
					$error("program_counter exp %0h got %0h", e.program_counter,
						result.program_counter);
					error_count++;
				end
				if (result.running !== e.running) begin
					$error("running exp %0b got %0b", e.running, result.running);
					error_count++;
				end
				if (result.zero_flag !== e.zero_flag) begin
					$error("zero_flag exp %0b got %0b", e.zero_flag, result.zero_flag);
					error_count++;
				end
				if (result.interrupt_enable !== e.interrupt_enable) begin
					$error("interrupt_enable exp %0b got %0b", e.interrupt_enable,
						result.interrupt_enable);
					error_count++;
				end
				if (result.fault !== e.fault) begin
					$error("fault exp %0d got %0d", e.fault, result.fault);
					error_count++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (pending_items.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (50) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// timeout
	initial begin
		#(12 * 1000000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
